// File: design/triangle_area_and_heights_unit_defines.svh
// ----------------------------------------------------------------------------
// Triangle area unit assertion macros
// Shared concurrent-check macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_AREA_AND_HEIGHTS_UNIT_DEFINES_SVH
`define TRIANGLE_AREA_AND_HEIGHTS_UNIT_DEFINES_SVH

// same-cycle implication
`define TAHA_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAHA_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/taha_pkg.sv
// ----------------------------------------------------------------------------
// Triangle area unit package
// Widths, stage counts and pipeline payload types.
// ----------------------------------------------------------------------------
package taha_pkg;

  localparam int SIDE_W      = 16;
  localparam int SUM_W       = 18;
  localparam int DIFF_W      = 17;
  localparam int X_W         = SUM_W + DIFF_W;   // (a+b+c)(b+c-a)
  localparam int Y_W         = 2 * DIFF_W;       // (a+c-b)(a+b-c)
  localparam int Y_LO_W      = 17;
  localparam int RAD_W       = 66;
  localparam int ROOT_W      = 33;
  localparam int REM_W       = ROOT_W + 2;
  localparam int HGT_W       = 18;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = HGT_W;

  typedef struct packed {
    logic              is_tri;
    logic [SIDE_W-1:0] a;
    logic [SIDE_W-1:0] b;
    logic [SIDE_W-1:0] c;
  } tri_tag_t;

  typedef struct packed {
    logic              is_tri;
    logic [ROOT_W-1:0] area;
    logic [SIDE_W-1:0] a;
    logic [SIDE_W-1:0] b;
    logic [SIDE_W-1:0] c;
  } div_tag_t;

  typedef struct packed {
    logic              is_tri;
    logic [ROOT_W-1:0] area;
    logic [HGT_W-1:0]  ha;
    logic [HGT_W-1:0]  hb;
    logic [HGT_W-1:0]  hc;
  } result_t;

endpackage

// File: design/taha_if.sv
// ----------------------------------------------------------------------------
// Triangle area unit channels
// Valid/ready channels for side triples and results.
// ----------------------------------------------------------------------------
interface taha_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] side_a;
  logic [15:0] side_b;
  logic [15:0] side_c;

  modport source(output valid, output side_a, output side_b, output side_c, input ready);
  modport sink(input valid, input side_a, input side_b, input side_c, output ready);
endinterface

interface taha_out_if;
  logic        valid;
  logic        ready;
  logic        is_triangle;
  logic [32:0] area_quarters;
  logic [17:0] height_a_quarters;
  logic [17:0] height_b_quarters;
  logic [17:0] height_c_quarters;

  modport source(output valid, output is_triangle, output area_quarters,
                 output height_a_quarters, output height_b_quarters,
                 output height_c_quarters, input ready);
  modport sink(input valid, input is_triangle, input area_quarters,
               input height_a_quarters, input height_b_quarters,
               input height_c_quarters, output ready);
endinterface

// File: design/taha_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, restoring digit-by-digit method, 33 stages.
// ----------------------------------------------------------------------------
module taha_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [taha_pkg::RAD_W-1:0]     in_rad,
  input  taha_pkg::tri_tag_t             in_tag,
  output logic                           out_vld,
  output logic [taha_pkg::ROOT_W-1:0]    out_root,
  output taha_pkg::tri_tag_t             out_tag
);
  import taha_pkg::*;

  logic              vld_r  [0:SQRT_STAGES-1];
  logic [RAD_W-1:0]  rad_r  [0:SQRT_STAGES-1];
  logic [REM_W-1:0]  rem_r  [0:SQRT_STAGES-1];
  logic [ROOT_W-1:0] root_r [0:SQRT_STAGES-1];
  tri_tag_t          tag_r  [0:SQRT_STAGES-1];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    tri_tag_t          tag_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign tag_in  = tag_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
      trial  = {2'b00, root_in, 2'b01};
      diff   = rem_sh - trial;
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        rem_r[k]  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_r[k] <= {root_in[ROOT_W-2:0], take};
        tag_r[k]  <= tag_in;
      end
    end
  end

  assign out_vld  = vld_r[SQRT_STAGES-1];
  assign out_root = root_r[SQRT_STAGES-1];
  assign out_tag  = tag_r[SQRT_STAGES-1];

endmodule

// File: design/taha_div3.sv
// ----------------------------------------------------------------------------
// Pipelined height dividers
// Three restoring dividers, one quotient bit per stage, 18 stages.
// ----------------------------------------------------------------------------
module taha_div3 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  taha_pkg::div_tag_t  in_tag,
  output logic                out_vld,
  output taha_pkg::result_t   out_res
);
  import taha_pkg::*;

  // {quotient bit, next remainder}
  function automatic logic [SIDE_W:0] div_step(input logic [SIDE_W-1:0] rem,
                                               input logic nbit,
                                               input logic [SIDE_W-1:0] d);
    logic [SIDE_W:0] sh;
    logic [SIDE_W:0] dx;
    logic [SIDE_W:0] sub;
    sh  = {rem, nbit};
    dx  = {1'b0, d};
    sub = sh - dx;
    if (sh >= dx) begin
      div_step = {1'b1, sub[SIDE_W-1:0]};
    end else begin
      div_step = {1'b0, sh[SIDE_W-1:0]};
    end
  endfunction

  logic              vld_r [0:DIV_STAGES-1];
  div_tag_t          tag_r [0:DIV_STAGES-1];
  logic [SIDE_W-1:0] ra_r  [0:DIV_STAGES-1];
  logic [SIDE_W-1:0] rb_r  [0:DIV_STAGES-1];
  logic [SIDE_W-1:0] rc_r  [0:DIV_STAGES-1];
  logic [HGT_W-1:0]  qa_r  [0:DIV_STAGES-1];
  logic [HGT_W-1:0]  qb_r  [0:DIV_STAGES-1];
  logic [HGT_W-1:0]  qc_r  [0:DIV_STAGES-1];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int BIT = DIV_STAGES - 1 - j;
    logic              vld_in;
    div_tag_t          tag_in;
    logic [SIDE_W-1:0] ra_in, rb_in, rc_in;
    logic [HGT_W-1:0]  qa_in, qb_in, qc_in;
    logic [ROOT_W:0]   num;
    logic [SIDE_W:0]   sa, sb, sc;

    if (j == 0) begin : g_first
      // numerator 2*area; its top bits seed the remainder
      assign vld_in = in_vld;
      assign tag_in = in_tag;
      assign ra_in  = in_tag.area[ROOT_W-1:ROOT_W-SIDE_W];
      assign rb_in  = in_tag.area[ROOT_W-1:ROOT_W-SIDE_W];
      assign rc_in  = in_tag.area[ROOT_W-1:ROOT_W-SIDE_W];
      assign qa_in  = '0;
      assign qb_in  = '0;
      assign qc_in  = '0;
    end else begin : g_next
      assign vld_in = vld_r[j-1];
      assign tag_in = tag_r[j-1];
      assign ra_in  = ra_r[j-1];
      assign rb_in  = rb_r[j-1];
      assign rc_in  = rc_r[j-1];
      assign qa_in  = qa_r[j-1];
      assign qb_in  = qb_r[j-1];
      assign qc_in  = qc_r[j-1];
    end

    always_comb begin
      num = {tag_in.area, 1'b0};
      sa  = div_step(ra_in, num[BIT], tag_in.a);
      sb  = div_step(rb_in, num[BIT], tag_in.b);
      sc  = div_step(rc_in, num[BIT], tag_in.c);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[j] <= tag_in;
        ra_r[j]  <= sa[SIDE_W-1:0];
        rb_r[j]  <= sb[SIDE_W-1:0];
        rc_r[j]  <= sc[SIDE_W-1:0];
        qa_r[j]  <= {qa_in[HGT_W-2:0], sa[SIDE_W]};
        qb_r[j]  <= {qb_in[HGT_W-2:0], sb[SIDE_W]};
        qc_r[j]  <= {qc_in[HGT_W-2:0], sc[SIDE_W]};
      end
    end
  end

  assign out_vld        = vld_r[DIV_STAGES-1];
  assign out_res.is_tri = tag_r[DIV_STAGES-1].is_tri;
  assign out_res.area   = tag_r[DIV_STAGES-1].area;
  assign out_res.ha     = qa_r[DIV_STAGES-1];
  assign out_res.hb     = qb_r[DIV_STAGES-1];
  assign out_res.hc     = qc_r[DIV_STAGES-1];

endmodule

// File: design/triangle_area_and_heights_unit.sv
// ----------------------------------------------------------------------------
// Triangle area and heights unit
// Integer Heron area and the three heights, in quarter units, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries side_a/b/c; a transfer happens when valid and ready are high.
//   out_ch carries is_triangle, area_quarters and the three heights, one
//   result per input, in order.
//   From input transfer to out_ch.valid an item passes one stage for sums
//   and the triangle test, three for the 66-bit Heron product (split into
//   35x17 partial products), 33 for the root (one bit per stage), 18 for
//   the height dividers (one quotient bit per stage) and the output
//   register.
//   Throughput is one item per cycle while the receiver does not stall; the
//   one-bit-per-stage root and divider pipelines set the depth, not the rate.
//   A side triple that is no strict triangle yields is_triangle = 0 and all
//   other fields 0.
//   Reset clears every valid bit; payload registers are left alone.
//   When the receiver stalls, the whole pipeline holds and in_ch.ready drops
//   until the output register is taken.
// ----------------------------------------------------------------------------
`include "triangle_area_and_heights_unit_defines.svh"

module triangle_area_and_heights_unit (
  input  logic       clk,
  input  logic       rst_n,
  taha_in_if.sink    in_ch,
  taha_out_if.source out_ch
);
  import taha_pkg::*;

  logic adv;

  // stage 1: sums, differences, triangle test
  logic              s1_vld_r;
  logic [SUM_W-1:0]  s1_sum_r;
  logic [DIFF_W-1:0] s1_d1_r, s1_d2_r, s1_d3_r;
  tri_tag_t          s1_tag_r;
  logic [DIFF_W-1:0] ab, ac, bc;
  logic              tri_ok;

  // stage 2: two half products
  logic              s2_vld_r;
  logic [X_W-1:0]    s2_x_r;
  logic [Y_W-1:0]    s2_y_r;
  tri_tag_t          s2_tag_r;

  // stage 3: partial products of x*y
  logic                  s3_vld_r;
  logic [X_W+Y_LO_W-1:0] s3_pp0_r, s3_pp1_r;
  tri_tag_t              s3_tag_r;

  // stage 4: radicand
  logic              s4_vld_r;
  logic [RAD_W-1:0]  s4_rad_r;
  tri_tag_t          s4_tag_r;

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  tri_tag_t          sq_tag;
  div_tag_t          dv_in;
  logic              dv_vld;
  result_t           dv_res;

  logic              out_vld_r;
  result_t           out_res_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    ab     = {1'b0, in_ch.side_a} + {1'b0, in_ch.side_b};
    ac     = {1'b0, in_ch.side_a} + {1'b0, in_ch.side_c};
    bc     = {1'b0, in_ch.side_b} + {1'b0, in_ch.side_c};
    tri_ok = (ab > {1'b0, in_ch.side_c}) && (ac > {1'b0, in_ch.side_b}) &&
             (bc > {1'b0, in_ch.side_a});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_ch.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r        <= {1'b0, ab} + {2'b00, in_ch.side_c};
      s1_d1_r         <= bc - {1'b0, in_ch.side_a};
      s1_d2_r         <= ac - {1'b0, in_ch.side_b};
      s1_d3_r         <= ab - {1'b0, in_ch.side_c};
      s1_tag_r.is_tri <= tri_ok;
      s1_tag_r.a      <= in_ch.side_a;
      s1_tag_r.b      <= in_ch.side_b;
      s1_tag_r.c      <= in_ch.side_c;

      s2_x_r   <= s1_sum_r * s1_d1_r;
      s2_y_r   <= s1_d2_r * s1_d3_r;
      s2_tag_r <= s1_tag_r;

      s3_pp0_r <= s2_x_r * s2_y_r[Y_LO_W-1:0];
      s3_pp1_r <= s2_x_r * s2_y_r[Y_W-1:Y_LO_W];
      s3_tag_r <= s2_tag_r;

      // P < 2^66 for any true triangle; wrap is harmless otherwise
      s4_rad_r <= RAD_W'({{Y_LO_W{1'b0}}, s3_pp0_r} + {s3_pp1_r, {Y_LO_W{1'b0}}});
      s4_tag_r <= s3_tag_r;

      if (dv_res.is_tri) begin
        out_res_r <= dv_res;
      end else begin
        out_res_r <= '0;
      end
    end
  end

  taha_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (s4_vld_r),
    .in_rad   (s4_rad_r),
    .in_tag   (s4_tag_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  always_comb begin
    dv_in.is_tri = sq_tag.is_tri;
    dv_in.area   = sq_root;
    dv_in.a      = sq_tag.a;
    dv_in.b      = sq_tag.b;
    dv_in.c      = sq_tag.c;
  end

  taha_div3 u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (sq_vld),
    .in_tag  (dv_in),
    .out_vld (dv_vld),
    .out_res (dv_res)
  );

  assign out_ch.valid             = out_vld_r;
  assign out_ch.is_triangle       = out_res_r.is_tri;
  assign out_ch.area_quarters     = out_res_r.area;
  assign out_ch.height_a_quarters = out_res_r.ha;
  assign out_ch.height_b_quarters = out_res_r.hb;
  assign out_ch.height_c_quarters = out_res_r.hc;

  `TAHA_CHK_NOW(a_tri_diffs_nonzero, s1_vld_r && s1_tag_r.is_tri,
    s1_d1_r != '0 && s1_d2_r != '0 && s1_d3_r != '0, "triangle with a zero factor")
  `TAHA_CHK_NOW(a_tri_area_nonzero, out_vld_r && out_res_r.is_tri,
    out_res_r.area != '0, "valid triangle with zero area")
  `TAHA_CHK_NOW(a_invalid_zeroed, out_vld_r && !out_res_r.is_tri,
    out_res_r.area == '0 && out_res_r.ha == '0 && out_res_r.hb == '0 && out_res_r.hc == '0,
    "non-triangle result not cleared")
  `TAHA_CHK_NEXT(a_stall_holds_pipe, out_vld_r && !out_ch.ready,
    out_vld_r && $stable(out_res_r) && $stable(s4_rad_r), "pipeline moved during stall")

endmodule

// File: test/tb_triangle_area_and_heights_unit.sv
// ----------------------------------------------------------------------------
// Triangle area and heights unit testbench
// Drives side triples through the valid/ready channels under random idling
// on both sides and a long receiver hold-off, and checks every result against
// an integer Heron area and height prediction, in order.
// ----------------------------------------------------------------------------
module tb_triangle_area_and_heights_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import taha_pkg::*;

  localparam int LATENCY   = 56;
  localparam int WDOG_MAX  = 5000;
  localparam int HOLD_LEN  = 300;

  typedef struct packed {
    logic              is_tri;
    logic [ROOT_W-1:0] area;
    logic [HGT_W-1:0]  ha;
    logic [HGT_W-1:0]  hb;
    logic [HGT_W-1:0]  hc;
  } tri_result_t;

  class tri_scoreboard;
    tri_result_t pending[$];
    int          mismatches;

    // floor(sqrt(p)) one bit at a time; p below 2^66
    function automatic logic [ROOT_W-1:0] root_of(logic [RAD_W-1:0] p);
      logic [ROOT_W-1:0] r;
      logic [ROOT_W-1:0] t;
      r = '0;
      for (int i = ROOT_W - 1; i >= 0; i--) begin
        t = r | (33'd1 << i);
        if ({67'd0, t} * {67'd0, t} <= {34'd0, p}) r = t;
      end
      return r;
    endfunction

    function void note_sides(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      tri_result_t      e;
      logic [17:0]      s;
      logic [RAD_W-1:0] p;
      logic [ROOT_W:0]  twice;
      e = '0;
      if ({2'b0, a} + b > c && {2'b0, a} + c > b && {2'b0, b} + c > a) begin
        s = {2'b0, a} + b + c;
        p = ({48'd0, s} * ({2'b0, b} + c - a)) *
            ({48'd0, {2'b0, a} + c - b} * ({2'b0, a} + b - c));
        e.is_tri = 1'b1;
        e.area   = root_of(p);
        twice    = {e.area, 1'b0};
        e.ha     = HGT_W'(twice / a);
        e.hb     = HGT_W'(twice / b);
        e.hc     = HGT_W'(twice / c);
      end
      pending.push_back(e);
    endfunction

    function void check_result(tri_result_t got);
      tri_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp tri=%0d area=%0d h=%0d/%0d/%0d",
                    " got tri=%0d area=%0d h=%0d/%0d/%0d"},
                   e.is_tri, e.area, e.ha, e.hb, e.hc,
                   got.is_tri, got.area, got.ha, got.hb, got.hc);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  taha_in_if  in_ch();
  taha_out_if out_ch();

  triangle_area_and_heights_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  tri_scoreboard sb = new();
  int  send_idle = 37;
  int  recv_idle = 46;
  bit  hold_req  = 1'b0;
  int  idle_cycles = 0;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.side_a = '0;
    in_ch.side_b = '0;
    in_ch.side_c = '0;
    out_ch.ready = 1'b0;
  end

  // scores results; receiver below: random stalls, or a long counted hold-off when asked
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.is_triangle, out_ch.area_quarters,
                       out_ch.height_a_quarters, out_ch.height_b_quarters,
                       out_ch.height_c_quarters});
  end

  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_sides(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.side_a <= a;
    in_ch.side_b <= b;
    in_ch.side_c <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sides(a, b, c);
  endtask

  task automatic send_random_triangle();
    logic [15:0] a, b, c;
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) begin
      // well formed: c aimed strictly between |a-b| and a+b, though the 16-bit cast can wrap it
      a = 16'($urandom);
      b = 16'($urandom);
      if (a == 0) a = 1;
      if (b == 0) b = 1;
      c = (a > b) ? 16'(a - b + 1 + $urandom_range(((b << 1) > 2 ? (b << 1) - 2 : 0)))
                  : 16'(b - a + 1 + $urandom_range(((a << 1) > 2 ? (a << 1) - 2 : 0)));
    end else if (sel < 7) begin
      a = 16'($urandom_range(20));
      b = 16'($urandom_range(20));
      c = 16'($urandom_range(20));
    end else if (sel < 8) begin
      a = 16'($urandom);
      b = a;
      c = 16'($urandom_range(16'hffff, 16'hff00));
    end else begin
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
    end
    send_sides(a, b, c);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_sides(16'hffff, 16'hffff, 16'hffff);
    send_sides(16'hffff, 16'hffff, 16'd1);
    send_sides(16'd1, 16'd1, 16'd1);
    send_sides(16'd3, 16'd4, 16'd5);
    send_sides(16'd0, 16'd0, 16'd0);
    send_sides(16'd0, 16'd5, 16'd5);
    send_sides(16'd5, 16'd0, 16'd5);
    send_sides(16'd5, 16'd5, 16'd0);
    send_sides(16'd1, 16'd2, 16'd3);     // flat
    send_sides(16'd2, 16'd3, 16'd1);
    send_sides(16'd3, 16'd1, 16'd2);
    send_sides(16'd1, 16'd1, 16'd5);
    send_sides(16'hffff, 16'h8000, 16'h7fff);
    send_sides(16'hffff, 16'h8000, 16'h8000);
    send_sides(16'h5555, 16'haaaa, 16'h7777);
    send_sides(16'd2, 16'd2, 16'd3);
    send_sides(16'd65534, 16'd65535, 16'd2);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 46; recv_idle = 37; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; hold_req = 1'b1; end
      for (int i = 0; i < 260; i++) send_random_triangle();
    end
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
